// ----- hdl/tic_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Group decoder package
// Shared constants and the request record passed from front to back.
// ----------------------------------------------------------------------------
package tic_pkg;

  localparam int BUF_SIZE = 32;
  localparam logic [5:0] MIN_COUNT = 6'd9;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_SHORT    = 3'd1;
  localparam logic [2:0] ST_CHECKSUM = 3'd2;
  localparam logic [2:0] ST_LABEL    = 3'd3;
  localparam logic [2:0] ST_DATA     = 3'd4;

  localparam logic [3:0] ID_PERIOD = 4'd6;
  localparam logic [3:0] ID_COLOUR = 4'd7;
  localparam logic [3:0] ID_AMPS   = 4'd8;
  localparam logic [3:0] ID_POWER  = 4'd9;

  // A finished group, already classified by the front end.
  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  group_id;
    logic        has_data;
    logic [2:0]  data_sel;   // tariff index 0-5, 6 none; or colour 0-2, 3 none
    logic [31:0] number;
  } group_req_t;

  function automatic logic [2:0] tariff_of(input logic [27:0] s);
    logic [2:0] r;
    unique case (s)
      {7'h48, 7'h43, 7'h4a, 7'h42}: r = 3'd0;
      {7'h48, 7'h50, 7'h4a, 7'h42}: r = 3'd1;
      {7'h48, 7'h43, 7'h4a, 7'h57}: r = 3'd2;
      {7'h48, 7'h50, 7'h4a, 7'h57}: r = 3'd3;
      {7'h48, 7'h43, 7'h4a, 7'h52}: r = 3'd4;
      {7'h48, 7'h50, 7'h4a, 7'h52}: r = 3'd5;
      default: r = 3'd6;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ----- hdl/tic_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Group decoder front end
// Collects bytes, keeps checksum and tokens, classifies the group at CR.
// ----------------------------------------------------------------------------
module tic_front (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               rx_valid,
  input  wire logic [7:0]         rx_byte,
  output logic                    rx_ready,
  output logic                    req_valid,
  output tic_pkg::group_req_t     req,
  input  wire logic               req_ready
);

  logic        receiving;
  logic [5:0]  byte_count;
  logic [5:0]  running_sum;
  logic [6:0]  delay_bytes [2];
  logic [2:0]  token_phase;
  logic [6:0]  label_chars [7];
  logic [2:0]  label_length;
  logic [6:0]  data_chars [4];
  logic [2:0]  data_length;
  logic [31:0] digit_accumulator;
  logic        digits_stopped;

  logic [6:0] c, d;
  logic       sep, take, put_l, put_d, is_dig;
  logic [5:0] cnt_inc;

  assign c = rx_byte[6:0];
  assign d = delay_bytes[0];
  assign sep = (d == 7'h20) || (d == 7'h09);
  assign rx_ready = req_ready;
  assign req_valid = rx_valid && receiving && (c == 7'h0d);
  assign take = rx_valid && rx_ready;
  assign cnt_inc = byte_count + 6'd1;
  assign is_dig = (d >= 7'h30) && (d <= 7'h39);

  always_comb begin
    put_l = 1'b0;
    put_d = 1'b0;
    if (byte_count >= 6'd2) begin
      unique case (token_phase)
        3'd0, 3'd1: put_l = !sep;
        3'd2, 3'd3: put_d = !sep;
        default: ;
      endcase
    end
  end

  // Classification of the group currently held.
  logic [2:0]  g_lab;
  logic [2:0]  tar, dtar;
  logic [1:0]  col;
  logic [6:0]  chk;
  always_comb begin
    g_lab = 3'd5;
    if (label_length >= 3'd3) begin
      priority if ({label_chars[0], label_chars[1], label_chars[2]} ==
                   {7'h42, 7'h42, 7'h52}) g_lab = 3'd0;
      else if ({label_chars[0], label_chars[1], label_chars[2]} ==
               {7'h50, 7'h54, 7'h45}) g_lab = 3'd1;
      else if ({label_chars[0], label_chars[1], label_chars[2]} ==
               {7'h44, 7'h45, 7'h4d}) g_lab = 3'd2;
      else if ({label_chars[0], label_chars[1], label_chars[2]} ==
               {7'h49, 7'h49, 7'h4e}) g_lab = 3'd3;
      else if ({label_chars[0], label_chars[1], label_chars[2]} ==
               {7'h50, 7'h41, 7'h50}) g_lab = 3'd4;
    end
    tar = 3'd6;
    if (label_length >= 3'd7)
      tar = tic_pkg::tariff_of({label_chars[3], label_chars[4], label_chars[5],
                                label_chars[6]});
    dtar = 3'd6;
    if (data_length >= 3'd4)
      dtar = tic_pkg::tariff_of({data_chars[0], data_chars[1], data_chars[2],
                                 data_chars[3]});
    col = 2'd3;
    if (data_length >= 3'd3) begin
      priority if ({data_chars[0], data_chars[1], data_chars[2]} ==
                   {7'h42, 7'h4c, 7'h45}) col = 2'd0;
      else if ({data_chars[0], data_chars[1], data_chars[2]} ==
               {7'h42, 7'h4c, 7'h41}) col = 2'd1;
      else if ({data_chars[0], data_chars[1], data_chars[2]} ==
               {7'h52, 7'h4f, 7'h55}) col = 2'd2;
    end
    chk = {1'b0, running_sum} + 7'h20;

    req = '0;
    req.number = digit_accumulator;
    req.has_data = (data_length != 3'd0);
    priority if (byte_count < tic_pkg::MIN_COUNT) req.status = tic_pkg::ST_SHORT;
    else if (chk != delay_bytes[1]) req.status = tic_pkg::ST_CHECKSUM;
    else if (g_lab == 3'd5 || (g_lab == 3'd0 && tar == 3'd6))
      req.status = tic_pkg::ST_LABEL;
    else begin
      req.group_id = (g_lab == 3'd0) ? {1'b0, tar} : ({1'b0, g_lab} + 4'd5);
      req.status = tic_pkg::ST_OK;
      req.data_sel = (g_lab == 3'd1) ? dtar : {1'b0, col};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      receiving <= 1'b0;
      byte_count <= '0;
      running_sum <= '0;
      delay_bytes[0] <= '0;
      delay_bytes[1] <= '0;
      token_phase <= '0;
      label_length <= '0;
      data_length <= '0;
      digit_accumulator <= '0;
      digits_stopped <= 1'b0;
    end else if (take) begin
      if (!receiving) begin
        if (c == 7'h0a) begin
          receiving <= 1'b1;
          byte_count <= '0;
          running_sum <= '0;
          delay_bytes[0] <= '0;
          delay_bytes[1] <= '0;
          token_phase <= '0;
          label_length <= '0;
          data_length <= '0;
          digit_accumulator <= '0;
          digits_stopped <= 1'b0;
        end
      end else if (c == 7'h0d) begin
        receiving <= 1'b0;
      end else begin
        if (byte_count >= 6'd2) begin
          running_sum <= running_sum + d[5:0];
          unique case (token_phase)
            3'd0: if (!sep) token_phase <= 3'd1;
            3'd1: if (sep) token_phase <= 3'd2;
            3'd2: if (!sep) token_phase <= 3'd3;
            3'd3: if (sep) token_phase <= 3'd4;
            default: ;
          endcase
        end
        if (put_l) begin
          if (label_length < 3'd7) begin
            label_chars[label_length] <= d;
            label_length <= label_length + 3'd1;
          end
        end
        if (put_d) begin
          if (data_length < 3'd4) data_chars[data_length[1:0]] <= d;
          if (data_length < 3'd7) data_length <= data_length + 3'd1;
          if (!digits_stopped && is_dig)
            digit_accumulator <= (digit_accumulator << 3) + (digit_accumulator << 1)
                                 + {28'd0, d[3:0]};
          else digits_stopped <= 1'b1;
        end
        delay_bytes[0] <= delay_bytes[1];
        delay_bytes[1] <= c;
        byte_count <= cnt_inc;
        if (cnt_inc >= 6'(tic_pkg::BUF_SIZE - 1)) receiving <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tic_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Group request queue
// Two-entry queue between the front and back ends.
// ----------------------------------------------------------------------------
module tic_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  input  wire tic_pkg::group_req_t in_req,
  output logic                     in_ready,
  output logic                     out_valid,
  output tic_pkg::group_req_t      out_req,
  input  wire logic                out_ready
);

  tic_pkg::group_req_t mem [2];
  logic wr_ptr, rd_ptr;
  logic [1:0] fill;
  logic push, pop;

  assign in_ready = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_req = mem[rd_ptr];
  assign push = in_valid && in_ready;
  assign pop = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= in_req;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop) rd_ptr <= !rd_ptr;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tic_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Group decoder back end
// Compares with stored values, commits changes and registers the result.
// ----------------------------------------------------------------------------
module tic_back (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                req_valid,
  input  wire tic_pkg::group_req_t req,
  output logic                     req_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [2:0]               status,
  output logic [3:0]               group_id,
  output logic [31:0]              value,
  output logic                     changed
);

  logic [31:0] energy_index [6];
  logic [7:0]  current_period, tomorrow_colour, current_amps;
  logic [15:0] apparent_power;

  logic [2:0]  st;
  logic [31:0] v;
  logic        chg;
  logic        take;

  assign req_ready = !out_valid || out_ready;
  assign take = req_valid && req_ready;

  always_comb begin
    st = req.status;
    v = '0;
    chg = 1'b0;
    if (st == tic_pkg::ST_OK) begin
      if (!req.has_data) st = tic_pkg::ST_DATA;
      else if (req.group_id <= 4'd5) begin
        v = req.number;
        chg = energy_index[req.group_id[2:0]] != v;
      end else if (req.group_id == tic_pkg::ID_PERIOD) begin
        if (req.data_sel == 3'd6) st = tic_pkg::ST_DATA;
        else begin
          v = {29'd0, req.data_sel};
          chg = current_period != v[7:0];
        end
      end else if (req.group_id == tic_pkg::ID_COLOUR) begin
        if (req.data_sel[1:0] == 2'd3) st = tic_pkg::ST_DATA;
        else begin
          v = {30'd0, req.data_sel[1:0]};
          chg = tomorrow_colour != v[7:0];
        end
      end else if (req.group_id == tic_pkg::ID_AMPS) begin
        v = {24'd0, req.number[7:0]};
        chg = current_amps != v[7:0];
      end else begin
        v = {16'd0, req.number[15:0]};
        chg = apparent_power != v[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int k = 0; k < 6; k++) energy_index[k] <= '0;
      current_period <= 8'hff;
      tomorrow_colour <= 8'hff;
      current_amps <= '0;
      apparent_power <= '0;
    end else begin
      if (take) begin
        out_valid <= 1'b1;
        status <= st;
        group_id <= (req.status == tic_pkg::ST_OK) ? req.group_id : 4'd0;
        value <= v;
        changed <= chg;
        if (chg) begin
          if (req.group_id <= 4'd5) energy_index[req.group_id[2:0]] <= v;
          else if (req.group_id == tic_pkg::ID_PERIOD) current_period <= v[7:0];
          else if (req.group_id == tic_pkg::ID_COLOUR) tomorrow_colour <= v[7:0];
          else if (req.group_id == tic_pkg::ID_AMPS) current_amps <= v[7:0];
          else apparent_power <= v[15:0];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// ----- hdl/tic_historic_group_decoder.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Path: a finished group is queued, then registered by the back end.
// Throughput: one byte request per cycle while the queue has room.
// Reset: synchronous, clears reception state and the stored values
// (period and colour read as unknown).
// ----------------------------------------------------------------------------
// Historic-mode teleinformation group decoder
// Front end tokenizes bytes, a small queue hands finished groups to the
// back end, which commits changed values and presents the result.
// ----------------------------------------------------------------------------
module tic_historic_group_decoder (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [2:0]       status,
  output logic [3:0]       group_id,
  output logic [31:0]      value,
  output logic             changed
);

  logic f_valid, f_ready, q_valid, q_ready;
  tic_pkg::group_req_t f_req, q_req;

  // The front end stalls only when the queue is full.
  tic_front u_front (
    .clk(clk), .rst(rst), .rx_valid(in_valid), .rx_byte(rx_byte),
    .rx_ready(in_ready), .req_valid(f_valid), .req(f_req), .req_ready(f_ready)
  );

  tic_queue u_queue (
    .clk(clk), .rst(rst), .in_valid(f_valid), .in_req(f_req), .in_ready(f_ready),
    .out_valid(q_valid), .out_req(q_req), .out_ready(q_ready)
  );

  tic_back u_back (
    .clk(clk), .rst(rst), .req_valid(q_valid), .req(q_req), .req_ready(q_ready),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .group_id(group_id), .value(value), .changed(changed)
  );

endmodule
`default_nettype wire

// ----- verif/tic_historic_group_decoder_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Group decoder testbench
// Feeds byte streams of framed groups (well-formed, damaged and noisy) into
// the decoder and compares every result against an in-bench predictor.
// ----------------------------------------------------------------------------
module tic_historic_group_decoder_tb;

  typedef struct packed {
    logic [2:0]  status;
    logic [3:0]  group_id;
    logic [31:0] value;
    logic        changed;
  } group_result_t;

  // Predictor of the decoder, holding its own copy of the state.
  class group_scoreboard;
    bit          receiving;
    logic [5:0]  nbytes;
    logic [5:0]  csum;
    logic [6:0]  lag0, lag1;
    int          phase;
    logic [6:0]  lab[7];
    int          lab_len;
    logic [6:0]  dat[4];
    int          dat_len;
    logic [31:0] digits;
    bit          digits_done;
    logic [31:0] energy[6];
    logic [7:0]  period, colour, amps;
    logic [15:0] power;
    group_result_t pending[$];
    int          errors;

    function void clear_all();
      receiving = 0;
      start_group();
      foreach (energy[k]) energy[k] = 0;
      period = 8'hff;
      colour = 8'hff;
      amps = 0;
      power = 0;
      pending.delete();
      errors = 0;
    endfunction

    function void start_group();
      nbytes = 0; csum = 0; lag0 = 0; lag1 = 0; phase = 0;
      lab_len = 0; dat_len = 0; digits = 0; digits_done = 0;
    endfunction

    function void put_label(logic [6:0] c);
      if (lab_len < 7) begin
        lab[lab_len] = c;
        lab_len++;
      end
    endfunction

    function void put_data(logic [6:0] c);
      if (dat_len < 4) dat[dat_len] = c;
      if (dat_len < 7) dat_len++;
      if (!digits_done && c >= "0" && c <= "9") digits = digits * 10 + 32'(c - "0");
      else digits_done = 1;
    endfunction

    function void split_token(logic [6:0] c);
      bit sep;
      sep = (c == 7'h20 || c == 7'h09);
      case (phase)
        0: if (!sep) begin phase = 1; put_label(c); end
        1: if (sep) phase = 2; else put_label(c);
        2: if (!sep) begin phase = 3; put_data(c); end
        3: if (sep) phase = 4; else put_data(c);
        default: ;
      endcase
    endfunction

    // Matches four stored characters against a tariff code; 6 when none.
    function int tariff_index(logic [6:0] a, logic [6:0] b, logic [6:0] c, logic [6:0] d);
      string codes[6];
      codes = '{"HCJB", "HPJB", "HCJW", "HPJW", "HCJR", "HPJR"};
      for (int k = 0; k < 6; k++)
        if (a == codes[k][0] && b == codes[k][1] && c == codes[k][2] && d == codes[k][3])
          return k;
      return 6;
    endfunction

    function group_result_t decode_group();
      group_result_t r;
      int g, t;
      string labels[5];
      string colours[3];
      labels = '{"BBR", "PTE", "DEM", "IIN", "PAP"};
      colours = '{"BLE", "BLA", "ROU"};
      r = '0;
      if (nbytes < tic_pkg::MIN_COUNT) begin r.status = tic_pkg::ST_SHORT; return r; end
      if ({1'b0, csum} + 7'h20 != lag1) begin
        r.status = tic_pkg::ST_CHECKSUM;
        return r;
      end
      g = 5;
      if (lab_len >= 3)
        for (int k = 0; k < 5 && g == 5; k++)
          if (lab[0] == labels[k][0] && lab[1] == labels[k][1] && lab[2] == labels[k][2])
            g = k;
      if (g == 5) begin r.status = tic_pkg::ST_LABEL; return r; end
      if (g == 0) begin
        t = (lab_len >= 7) ? tariff_index(lab[3], lab[4], lab[5], lab[6]) : 6;
        if (t == 6) begin r.status = tic_pkg::ST_LABEL; return r; end
        r.group_id = 4'(t);
      end else begin
        r.group_id = 4'(g + 5);
      end
      if (dat_len == 0) begin r.status = tic_pkg::ST_DATA; return r; end
      if (r.group_id <= 5) begin
        r.value = digits;
        r.changed = energy[r.group_id] != digits;
        energy[r.group_id] = digits;
      end else if (r.group_id == tic_pkg::ID_PERIOD) begin
        t = (dat_len >= 4) ? tariff_index(dat[0], dat[1], dat[2], dat[3]) : 6;
        if (t == 6) begin r.status = tic_pkg::ST_DATA; return r; end
        r.value = 32'(t);
        r.changed = period != 8'(t);
        period = 8'(t);
      end else if (r.group_id == tic_pkg::ID_COLOUR) begin
        t = 3;
        if (dat_len >= 3)
          for (int k = 0; k < 3 && t == 3; k++)
            if (dat[0] == colours[k][0] && dat[1] == colours[k][1] && dat[2] == colours[k][2])
              t = k;
        if (t == 3) begin r.status = tic_pkg::ST_DATA; return r; end
        r.value = 32'(t);
        r.changed = colour != 8'(t);
        colour = 8'(t);
      end else if (r.group_id == tic_pkg::ID_AMPS) begin
        r.value = digits & 32'hff;
        r.changed = amps != r.value[7:0];
        amps = r.value[7:0];
      end else begin
        r.value = digits & 32'hffff;
        r.changed = power != r.value[15:0];
        power = r.value[15:0];
      end
      return r;
    endfunction

    // Notes one accepted byte request and queues the result it causes, if any.
    function void note_byte(logic [7:0] raw);
      logic [6:0] c;
      c = raw[6:0];
      if (!receiving) begin
        if (c == 7'h0a) begin
          start_group();
          receiving = 1;
        end
      end else if (c == 7'h0d) begin
        receiving = 0;
        pending.push_back(decode_group());
      end else begin
        if (nbytes >= 2) begin
          csum = csum + lag0[5:0];
          split_token(lag0);
        end
        lag0 = lag1;
        lag1 = c;
        nbytes++;
        if (nbytes >= tic_pkg::BUF_SIZE - 1) receiving = 0;
      end
    endfunction

    function void check_result(group_result_t got);
      group_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.status !== want.status || got.group_id !== want.group_id ||
          got.value !== want.value || got.changed !== want.changed) begin
        $display("%0t: expected st=%0d id=%0d val=%0d chg=%0d, got st=%0d id=%0d val=%0d chg=%0d",
                 $time, want.status, want.group_id, want.value, want.changed,
                 got.status, got.group_id, got.value, got.changed);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst = 1;
  logic        in_valid = 0;
  logic        in_ready;
  logic [7:0]  rx_byte = 0;
  logic        out_valid;
  logic        out_ready = 0;
  logic [2:0]  status;
  logic [3:0]  group_id;
  logic [31:0] value;
  logic        changed;

  group_scoreboard board;
  int burst_left = 0;
  int sent = 0;

  always #5 clk = ~clk;

  tic_historic_group_decoder dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .rx_byte(rx_byte),
    .out_valid(out_valid), .out_ready(out_ready), .status(status),
    .group_id(group_id), .value(value), .changed(changed)
  );

  // Requests are noted and results checked at the rising edge, where the
  // handshake actually takes place.
  always @(posedge clk) begin
    if (!rst && in_valid && in_ready) board.note_byte(rx_byte);
    if (!rst && out_valid && out_ready) board.check_result({status, group_id, value, changed});
  end

  // The receiver stalls on its own pattern: a phase counter mixed with
  // random stretches, including long spells of constant readiness.
  int stall_phase = 0;
  always @(negedge clk) begin
    stall_phase = (stall_phase + 1) % 64;
    if (stall_phase < 20) out_ready <= 1;
    else if (stall_phase < 40) out_ready <= ($urandom_range(0, 3) != 0);
    else out_ready <= $urandom_range(0, 1);
  end

  // Sends one byte request; bursts of random length with random gaps between.
  task automatic send_byte(logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) @(negedge clk);
    end
    burst_left--;
    in_valid = 1;
    rx_byte = b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sent++;
    @(negedge clk);
    in_valid = 0;
  endtask

  // Bit 7 carries parity, so it is set at random on every character.
  task automatic send_char(logic [6:0] c);
    send_byte({1'($urandom_range(0, 1)), c});
  endtask

  // Sends a whole framed group: line feed, body, separator, checksum, return.
  task automatic send_group(string body, bit bad_sum);
    logic [5:0] s;
    logic [6:0] ck;
    logic [7:0] ch;
    s = 0;
    foreach (body[k]) begin
      ch = body[k];
      s += ch[5:0];
    end
    ck = {1'b0, s} + 7'h20;
    if (bad_sum) ck = ck ^ 7'h01 ^ 7'($urandom_range(0, 1) << 1);
    send_char(7'h0a);
    foreach (body[k]) begin
      ch = body[k];
      send_char(ch[6:0]);
    end
    send_char(($urandom_range(0, 1)) ? 7'h20 : 7'h09);
    send_char(ck);
    send_char(7'h0d);
  endtask

  function automatic string pick_label();
    string tariffs[6];
    string others[4];
    tariffs = '{"HCJB", "HPJB", "HCJW", "HPJW", "HCJR", "HPJR"};
    others = '{"PTEC", "DEMAIN", "IINST", "PAPP"};
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return {"BBR", tariffs[$urandom_range(0, 5)]};
      4: return "BBRHXJB";
      5: return "XYZ";
      6: return "BB";
      default: return others[$urandom_range(0, 3)];
    endcase
  endfunction

  function automatic string pick_data(string label);
    string tariffs[6];
    string colours[4];
    string d;
    tariffs = '{"HCJB", "HPJB", "HCJW", "HPJW", "HCJR", "HPJR"};
    colours = '{"BLE", "BLA", "ROU", "----"};
    if ($urandom_range(0, 15) == 0) return "XQ-1";
    if (label == "PTEC")
      return ($urandom_range(0, 5) == 0) ? "HCJZ" : tariffs[$urandom_range(0, 5)];
    if (label == "DEMAIN") return colours[$urandom_range(0, 3)];
    d = "";
    repeat ($urandom_range(1, 11)) d = {d, string'(8'("0" + $urandom_range(0, 9)))};
    return d;
  endfunction

  // A well-formed group with random content, sometimes with a bad checksum.
  task automatic send_random_group();
    string label;
    label = pick_label();
    send_group({label, " ", pick_data(label)}, $urandom_range(0, 9) == 0);
  endtask

  task automatic wait_drained();
    while (board.pending.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  initial begin
    board = new();
    board.clear_all();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 0;

    // Directed part: idle bytes including a stray return, every label kind,
    // a short group, a checksum error, an unknown label with tab separators, digits
    // stopped by a sign, a long label, an embedded line feed and an overrun.
    send_byte(8'h0d);
    send_byte(8'hff);
    send_group("BBRHCJB 000123456", 0);
    send_group("BBRHPJR 999999999999", 0);
    send_group("PTEC HPJW", 0);
    send_group("DEMAIN ROU", 0);
    send_group("IINST 255", 0);
    send_group("PAPP 70000", 0);
    send_group("PAPP 12-4", 0);
    send_group("IIN", 0);
    send_group("ADCO\t\t 0", 0);
    send_group("IINST 256", 1);
    send_group("PT\nC HCJB", 0);
    send_char(7'h0a); send_char(7'h41); send_char(7'h0d);
    send_char(7'h0a);
    repeat (40) send_char(7'h41);
    send_char(7'h0d);
    wait_drained();   // a full pause with nothing outstanding

    // Random part: mostly well-formed groups with random content, the rest
    // raw noise bytes of every value.
    while (sent < 540) begin
      if ($urandom_range(0, 5) == 0) send_byte(8'($urandom_range(0, 255)));
      else send_random_group();
      if ($urandom_range(0, 40) == 0) wait_drained();
    end
    send_group("PAPP 1", 0);
    wait_drained();
    repeat (20) @(negedge clk);
    if (board.errors == 0 && board.pending.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  initial begin
    #5ms;
    $display("Verification failed");
    $finish;
  end

endmodule
